// ===== hw/rtl/gepr_pkg.sv =====
// shared types and constants of the graph edge partition router
`default_nettype none
package gepr_pkg;

   localparam int unsigned NODE_W  = 17;   // width of node counts, sizes and boundaries
   localparam int unsigned EP_W    = 20;   // endpoint width
   localparam int unsigned MAP_W   = 16;   // renumbering map entry width
   localparam int unsigned PART_W  = 16;   // partition index width
   localparam int unsigned CNT_W   = 24;   // per-device edge count width
   localparam int unsigned DIV_STEPS = 17; // quotient bits, one per cycle
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   // csr register indexes
   localparam logic [2:0] CSR_NODE_COUNT    = 3'd0;
   localparam logic [2:0] CSR_DEVICE_COUNT  = 3'd1;
   localparam logic [2:0] CSR_CPU_PART_SIZE = 3'd2;
   localparam logic [2:0] CSR_GPU_PART_SIZE = 3'd3;
   localparam logic [2:0] CSR_START_DEV1    = 3'd4;
   localparam logic [2:0] CSR_START_DEV2    = 3'd5;
   localparam logic [2:0] CSR_START_DEV3    = 3'd6;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_EDGE = 1'b1;

   typedef struct packed {
      logic            mode;
      logic [EP_W-1:0] endpoint_a;
      logic [EP_W-1:0] endpoint_b;
   } req_type;

   typedef struct packed {
      logic [1:0]        target_device;
      logic [PART_W-1:0] partition_index;
      logic [EP_W-1:0]   routed_a;
      logic [EP_W-1:0]   routed_b;
      logic [CNT_W-1:0]  device_edges;
      logic              last_copy;
   } rsp_type;

   typedef struct packed {
      logic [NODE_W-1:0] dividend;
      logic [NODE_W-1:0] divisor;
   } div_req_type;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_RDB   = 8'b0000_0010,
      S_RDY   = 8'b0000_0100,
      S_LOCX  = 8'b0000_1000,
      S_DIVX  = 8'b0001_0000,
      S_LOCY  = 8'b0010_0000,
      S_DIVY  = 8'b0100_0000,
      S_EMIT  = 8'b1000_0000
   } state_type;

endpackage
`default_nettype wire

// ===== hw/rtl/graph_edge_partition_router.sv =====
// top level of the graph edge partition router
//
//  channel   ports                                        transfer when
//  request   start, busy, req_payload                     start & !busy
//  result    rsp_valid, rsp_payload                       rsp_valid (one cycle)
//  csr       csr_valid, csr_ready, csr_index, csr_wdata   csr_valid & csr_ready
//
// a load item is taken with busy staying low
// an edge item keeps busy high through both map reads, a pass of the shared
//    17-step divider for each local endpoint and the sending of its copies
// results leave from a register, one per cycle, second copy right after the first;
//    the last copy shows in the same cycle that busy drops
// reset is synchronous; the renumbering map has no clearing pass
// results cannot be stalled; csr writes are always taken
`default_nettype none
module graph_edge_partition_router #(
   parameter int unsigned MAX_NODES   = 65536,
   parameter int unsigned MAX_DEVICES = 4
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   output logic                 busy,
   input  wire gepr_pkg::req_type req_payload,
   output logic                 rsp_valid,
   output gepr_pkg::rsp_type    rsp_payload,
   input  wire                  csr_valid,
   output logic                 csr_ready,
   input  wire [2:0]            csr_index,
   input  wire [gepr_pkg::NODE_W-1:0] csr_wdata
);
   import gepr_pkg::*;

   localparam int unsigned AW   = $clog2(MAX_NODES);
   localparam int unsigned NDEV = (MAX_DEVICES < 4) ? MAX_DEVICES : 4;
   localparam int unsigned DW   = $clog2(NDEV);

   // configuration registers
   logic [NODE_W-1:0] node_count_ff;
   logic [2:0]        device_count_ff;
   logic [NODE_W-1:0] cpu_size_ff;
   logic [NODE_W-1:0] gpu_size_ff;
   logic [NODE_W-1:0] start1_ff, start2_ff, start3_ff;

   // item state
   state_type         state_ff, state_in;
   logic [EP_W-1:0]   ea_ff, eb_ff;
   logic [EP_W-1:0]   x_ff, y_ff;
   logic              lx_ff, ly_ff;
   logic [1:0]        dx_ff, dy_ff;
   logic [PART_W-1:0] px_ff, py_ff;
   logic [CNT_W-1:0]  count_ff [NDEV];
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;
   logic              second_ff;   // second copy still to send

   logic              accept;
   logic              map_we;
   logic [AW-1:0]     map_raddr;
   logic [MAP_W-1:0]  map_rdata;

   // shared locate logic
   logic [EP_W-1:0]   loc_node;
   logic              loc_local;
   logic [1:0]        loc_dev;
   logic [NODE_W-1:0] loc_off;
   logic [NODE_W-1:0] loc_size;
   logic [2:0]        dev_used;
   logic [NODE_W-1:0] start_all [4];
   logic              found;

   logic              div_start;
   logic              div_done;
   div_req_type       div_req;
   logic [NODE_W-1:0] div_quo;

   logic              copy_y;
   logic [1:0]        emit_dev;
   logic [CNT_W-1:0]  emit_cnt;
   logic [CNT_W-1:0]  emit_next;

   function automatic logic in_map(input logic [EP_W-1:0] e);
      return 21'(e) < 21'(MAX_NODES);
   endfunction

   function automatic logic [EP_W-1:0] renumber(input logic [EP_W-1:0] e,
                                               input logic [MAP_W-1:0] m,
                                               input logic [NODE_W-1:0] nc);
      logic hit;
      hit = (e < EP_W'(nc)) && in_map(e);
      return hit ? EP_W'(m) : e;
   endfunction

   assign accept    = start && !busy;
   assign busy      = state_ff != S_IDLE;
   assign csr_ready = 1'b1;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff   <= '0;
         device_count_ff <= 3'd2;
         cpu_size_ff     <= NODE_W'(1);
         gpu_size_ff     <= NODE_W'(1);
         start1_ff       <= '0;
         start2_ff       <= '0;
         start3_ff       <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_NODE_COUNT:    node_count_ff   <= csr_wdata;
            CSR_DEVICE_COUNT:  device_count_ff <= csr_wdata[2:0];
            CSR_CPU_PART_SIZE: cpu_size_ff     <= csr_wdata;
            CSR_GPU_PART_SIZE: gpu_size_ff     <= csr_wdata;
            CSR_START_DEV1:    start1_ff       <= csr_wdata;
            CSR_START_DEV2:    start2_ff       <= csr_wdata;
            CSR_START_DEV3:    start3_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   // renumbering map: written by load items, read twice per edge item
   assign map_we    = accept && (req_payload.mode == MODE_LOAD)
                      && in_map(req_payload.endpoint_a);
   assign map_raddr = (state_ff == S_IDLE) ? req_payload.endpoint_a[AW-1:0]
                                           : eb_ff[AW-1:0];

   gepr_ram #(
      .WIDTH (MAP_W),
      .DEPTH (MAX_NODES)
   ) u_map (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (req_payload.endpoint_a[AW-1:0]),
      .wr_data (req_payload.endpoint_b[MAP_W-1:0]),
      .rd_addr (map_raddr),
      .rd_data (map_rdata)
   );

   // device search and partition offset for x or y
   assign start_all[0] = '0;
   assign start_all[1] = start1_ff;
   assign start_all[2] = start2_ff;
   assign start_all[3] = start3_ff;

   always_comb begin
      // clamp the device count to the supported range
      if (device_count_ff < 3'd2) begin
         dev_used = 3'd2;
      end else if (device_count_ff > 3'(NDEV)) begin
         dev_used = 3'(NDEV);
      end else begin
         dev_used = device_count_ff;
      end
   end

   always_comb begin
      loc_node  = (state_ff == S_LOCY) ? y_ff : x_ff;
      loc_local = loc_node < EP_W'(node_count_ff);
      loc_dev   = 2'(dev_used - 3'd1);
      found     = 1'b0;
      for (int i = 1; i < 4; i++) begin
         if (!found && (3'(i) < dev_used) && (loc_node[NODE_W-1:0] < start_all[i])) begin
            loc_dev = 2'(i - 1);
            found   = 1'b1;
         end
      end
      loc_off  = loc_node[NODE_W-1:0] - start_all[loc_dev];
      loc_size = (loc_dev == 2'd0) ? cpu_size_ff : gpu_size_ff;
      if (loc_size == '0) begin
         loc_size = NODE_W'(1);
      end
   end

   assign div_start       = ((state_ff == S_LOCX) || (state_ff == S_LOCY)) && loc_local;
   assign div_req.dividend = loc_off;
   assign div_req.divisor  = loc_size;

   gepr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_quo)
   );

   // second copy rule
   always_comb begin
      copy_y = 1'b0;
      if (ly_ff) begin
         if (dy_ff == 2'd0) begin
            copy_y = !(lx_ff && dx_ff == 2'd0);
         end else begin
            copy_y = !(lx_ff && dx_ff == dy_ff && px_ff == py_ff);
         end
      end
   end

   // which copy goes out this cycle: x first, y after it
   assign emit_dev  = (second_ff || !lx_ff) ? dy_ff : dx_ff;
   assign emit_cnt  = count_ff[emit_dev[DW-1:0]];
   assign emit_next = (emit_cnt == CNT_MAX) ? emit_cnt : emit_cnt + CNT_W'(1);

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_payload.mode == MODE_EDGE) begin
               state_in = S_RDB;
            end
         end
         S_RDB:  state_in = S_RDY;
         S_RDY:  state_in = S_LOCX;
         S_LOCX: state_in = loc_local ? S_DIVX : S_LOCY;
         S_DIVX: state_in = div_done ? S_LOCY : S_DIVX;
         S_LOCY: state_in = loc_local ? S_DIVY : S_EMIT;
         S_DIVY: state_in = div_done ? S_EMIT : S_DIVY;
         S_EMIT: begin
            if (!second_ff && lx_ff && copy_y) begin
               state_in = S_EMIT;
            end else begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
         for (int i = 0; i < NDEV; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= 1'b0;
         if (state_ff == S_EMIT) begin
            // x copy then, if needed, y copy in the next cycle
            if ((lx_ff && !second_ff) || copy_y) begin
               rsp_valid_ff                <= 1'b1;
               count_ff[emit_dev[DW-1:0]]  <= emit_next;
            end
            second_ff <= !second_ff && lx_ff && copy_y;
         end
      end
   end

   // item datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         ea_ff <= req_payload.endpoint_a;
         eb_ff <= req_payload.endpoint_b;
      end
      if (state_ff == S_RDB) begin
         x_ff <= renumber(ea_ff, map_rdata, node_count_ff);
      end
      if (state_ff == S_RDY) begin
         y_ff <= renumber(eb_ff, map_rdata, node_count_ff);
      end
      if (state_ff == S_LOCX) begin
         lx_ff <= loc_local;
         dx_ff <= loc_dev;
      end
      if (state_ff == S_DIVX && div_done) begin
         px_ff <= div_quo[PART_W-1:0];
      end
      if (state_ff == S_LOCY) begin
         ly_ff <= loc_local;
         dy_ff <= loc_dev;
      end
      if (state_ff == S_DIVY && div_done) begin
         py_ff <= div_quo[PART_W-1:0];
      end
      if (state_ff == S_EMIT) begin
         rsp_ff.target_device   <= emit_dev;
         rsp_ff.partition_index <= (second_ff || !lx_ff) ? py_ff : px_ff;
         rsp_ff.routed_a        <= x_ff;
         rsp_ff.routed_b        <= y_ff;
         rsp_ff.device_edges    <= emit_next;
         // a lone y copy is also the last one
         rsp_ff.last_copy       <= second_ff || !lx_ff || !copy_y;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/gepr_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
`default_nettype none
module gepr_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 65536
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire [WIDTH-1:0]          wr_data,
   input  wire [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ===== hw/rtl/gepr_div.sv =====
// iterative restoring divider, one quotient bit per cycle
`default_nettype none
module gepr_div (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   input  wire gepr_pkg::div_req_type req,
   output logic                 done,
   output logic [gepr_pkg::NODE_W-1:0] quotient
);
   import gepr_pkg::*;

   logic              busy_ff;
   logic              done_ff;
   logic [4:0]        step_ff;
   logic [NODE_W-1:0] rem_ff;
   logic [NODE_W-1:0] quo_ff;
   logic [NODE_W-1:0] dsr_ff;

   logic [NODE_W:0]   trial;
   logic              fits;

   assign trial = {rem_ff, quo_ff[NODE_W-1]};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 5'd1;
            if (step_ff == 5'(DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= req.dividend;
         dsr_ff <= req.divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? NODE_W'(trial - {1'b0, dsr_ff}) : trial[NODE_W-1:0];
         quo_ff <= {quo_ff[NODE_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/gepr_checker.sv =====
// port-level checks of the graph edge partition router and their bind
`default_nettype none
module gepr_checker (
   input wire               clock,
   input wire               reset,
   input wire               start,
   input wire               busy,
   input wire gepr_pkg::req_type req_payload,
   input wire               rsp_valid,
   input wire gepr_pkg::rsp_type rsp_payload
);
   import gepr_pkg::*;

   // a first copy is always followed at once by the second
   a_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.last_copy |=> rsp_valid)
      else $error("second copy missing");

   // the final copy ends the burst
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.last_copy |=> !rsp_valid)
      else $error("result after last copy");

   // a result leaves the cycle after an edge was still in flight
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result while idle");

   // a load transfer gives no result and leaves the block idle
   a_load: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_payload.mode == MODE_LOAD |=> !rsp_valid && !busy)
      else $error("load item produced activity");
endmodule

bind graph_edge_partition_router gepr_checker u_gepr_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_payload (rsp_payload)
);
`default_nettype wire

// ===== bench/tb_graph_edge_partition_router.sv =====
// self-checking testbench for the graph edge partition router
module tb_graph_edge_partition_router;
   import gepr_pkg::*;

   localparam int unsigned MAP_DEPTH     = 65536;  // map entries, the block's default MAX_NODES
   localparam int unsigned DEV_LIMIT     = 4;      // devices the block can address
   localparam int unsigned GAP_MAX       = 13;     // longest pause before a request
   localparam int unsigned SETTLE_CYCLES = 60;     // an edge with no copy may still be in flight
   localparam int unsigned STALL_LIMIT   = 2000;   // cycles with no transfer before giving up
   localparam int unsigned RANDOM_ITEMS  = 1600;
   localparam int unsigned PRINT_LIMIT   = 50;

   typedef enum bit {ROW_ITEM, ROW_CSR} row_kind_type;

   // one row of the directed table: a request or a register write, and for
   // requests whose outcome is obvious the copies typed in by hand
   typedef struct {
      row_kind_type      kind;
      req_type           req;
      logic [2:0]        csr_idx;
      logic [NODE_W-1:0] csr_val;
      int                n_typed;   // -1 leaves the outcome to the routing model
      rsp_type           exp0;
      rsp_type           exp1;
   } stim_row_type;

   // ---------------------------------------------------------------- dut side
   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              start       = 1'b0;
   req_type           req_payload = '0;
   logic              csr_valid   = 1'b0;
   logic [2:0]        csr_index   = '0;
   logic [NODE_W-1:0] csr_wdata   = '0;
   logic              busy;
   logic              csr_ready;
   logic              rsp_valid;
   rsp_type           rsp_payload;

   graph_edge_partition_router i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------ routing model state
   logic [MAP_W-1:0]  node_map [MAP_DEPTH];
   bit                map_written [MAP_DEPTH];
   int unsigned       loaded_nodes [$];      // every map index written so far
   logic [CNT_W-1:0]  edge_count [DEV_LIMIT];
   logic [NODE_W-1:0] cfg_nodes;
   logic [2:0]        cfg_devices;
   logic [NODE_W-1:0] cfg_cpu_size;
   logic [NODE_W-1:0] cfg_gpu_size;
   logic [NODE_W-1:0] cfg_start [DEV_LIMIT]; // entry 0 is the cpu, always node 0

   rsp_type     pending_copies [$];          // copies still owed by the block, oldest first
   int unsigned mismatches   = 0;
   int unsigned items_sent   = 0;
   int unsigned edges_sent   = 0;
   int unsigned copies_seen  = 0;
   int unsigned phases       = 0;
   int unsigned quiet_cycles = 0;
   bit          no_idle      = 1'b0;
   bit          settled      = 1'b1;

   task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   task automatic apply_csr(logic [2:0] idx, logic [NODE_W-1:0] val);
      case (idx)
         CSR_NODE_COUNT:    cfg_nodes    = val;
         CSR_DEVICE_COUNT:  cfg_devices  = val[2:0];
         CSR_CPU_PART_SIZE: cfg_cpu_size = val;
         CSR_GPU_PART_SIZE: cfg_gpu_size = val;
         CSR_START_DEV1:    cfg_start[1] = val;
         CSR_START_DEV2:    cfg_start[2] = val;
         CSR_START_DEV3:    cfg_start[3] = val;
         default: ;
      endcase
   endtask

   // device count is clamped into 2..DEV_LIMIT
   function automatic int unsigned devices_used();
      int unsigned n;
      n = cfg_devices;
      if (n < 2) n = 2;
      if (n > DEV_LIMIT) n = DEV_LIMIT;
      return n;
   endfunction

   // only local endpoints inside the map are renumbered
   function automatic logic [EP_W-1:0] renumbered(logic [EP_W-1:0] e);
      if (e < cfg_nodes && e < MAP_DEPTH) return EP_W'(node_map[e[15:0]]);
      return e;
   endfunction

   // device and partition of a node, 0 when the node is remote
   function automatic bit locate_node(input logic [EP_W-1:0] x, output logic [1:0] dev,
                                      output logic [PART_W-1:0] part);
      int unsigned n, d, size, offset;
      bit found;
      dev = '0;
      part = '0;
      if (x >= cfg_nodes) return 1'b0;
      n = devices_used();
      d = n - 1;
      found = 1'b0;
      for (int unsigned i = 1; i < n; i++) begin
         if (!found && x < cfg_start[i]) begin
            d = i - 1;
            found = 1'b1;
         end
      end
      size = (d == 0) ? cfg_cpu_size : cfg_gpu_size;
      if (size == 0) size = 1;
      offset = x - cfg_start[d];
      dev = 2'(d);
      part = PART_W'(offset / size);   // wide quotients wrap to 16 bits
      return 1'b1;
   endfunction

   function automatic logic [CNT_W-1:0] bump_count(logic [1:0] dev);
      if (edge_count[dev] != CNT_MAX) edge_count[dev] = edge_count[dev] + 1'b1;
      return edge_count[dev];
   endfunction

   // applies one request to the model, returns how many copies it causes
   function automatic int route_item(input req_type r, output rsp_type c0, output rsp_type c1);
      logic [EP_W-1:0]   x, y;
      logic [1:0]        dx, dy;
      logic [PART_W-1:0] px, py;
      bit                lx, ly, copy_y;
      rsp_type           cy;
      int                n;
      c0 = '0;
      c1 = '0;
      n = 0;
      if (r.mode == MODE_LOAD) begin
         if (r.endpoint_a < MAP_DEPTH) begin
            node_map[r.endpoint_a[15:0]] = r.endpoint_b[MAP_W-1:0];
            if (!map_written[r.endpoint_a[15:0]]) begin
               map_written[r.endpoint_a[15:0]] = 1'b1;
               loaded_nodes = {loaded_nodes, 32'(r.endpoint_a)};
            end
         end
         return 0;
      end
      x = renumbered(r.endpoint_a);
      y = renumbered(r.endpoint_b);
      lx = locate_node(x, dx, px);
      ly = locate_node(y, dy, py);
      copy_y = 1'b0;
      if (ly) begin
         // a cpu second endpoint is dropped when the first is on the cpu too
         if (dy == 0) copy_y = !(lx && dx == 0);
         else         copy_y = !(lx && dx == dy && px == py);
      end
      if (lx) begin
         c0 = '{target_device: dx, partition_index: px, routed_a: x, routed_b: y,
                device_edges: bump_count(dx), last_copy: 1'b0};
         n++;
      end
      if (copy_y) begin
         cy = '{target_device: dy, partition_index: py, routed_a: x, routed_b: y,
                device_edges: bump_count(dy), last_copy: 1'b0};
         if (lx) c1 = cy;
         else    c0 = cy;
         n++;
      end
      if (n == 1) c0.last_copy = 1'b1;
      if (n == 2) c1.last_copy = 1'b1;
      return n;
   endfunction

   // ------------------------------------------------------------ result check
   // results cannot be held off, so every strobe is a transfer
   always @(posedge clock) begin : check_copies
      rsp_type want;
      if (!reset && rsp_valid) begin
         copies_seen++;
         if (pending_copies.size() == 0) begin
            report_mismatch("edge copy with none outstanding", 64'(rsp_payload), 0);
         end else begin
            want = pending_copies.pop_front();
            if (rsp_payload.target_device !== want.target_device)
               report_mismatch("target_device", rsp_payload.target_device, want.target_device);
            if (rsp_payload.partition_index !== want.partition_index)
               report_mismatch("partition_index", rsp_payload.partition_index,
                               want.partition_index);
            if (rsp_payload.routed_a !== want.routed_a)
               report_mismatch("routed_a", rsp_payload.routed_a, want.routed_a);
            if (rsp_payload.routed_b !== want.routed_b)
               report_mismatch("routed_b", rsp_payload.routed_b, want.routed_b);
            if (rsp_payload.device_edges !== want.device_edges)
               report_mismatch("device_edges", rsp_payload.device_edges, want.device_edges);
            if (rsp_payload.last_copy !== want.last_copy)
               report_mismatch("last_copy", rsp_payload.last_copy, want.last_copy);
         end
      end
   end

   // watchdog: any transfer on any channel counts as progress
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("[%0t] no transfer for %0d cycles, %0d copies outstanding",
                  $time, quiet_cycles, pending_copies.size());
         $display("tb_graph_edge_partition_router failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- drivers
   // waits out a random gap, holds the request until the transfer and then
   // queues the copies it owes; start stays high if the next gap is zero
   task automatic send_item(input req_type r, input int n_typed = -1,
                            input rsp_type t0 = '0, input rsp_type t1 = '0);
      rsp_type     c0, c1;
      int          n;
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(GAP_MAX, 0);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (busy !== 1'b0);
      settled = 1'b0;
      n = route_item(r, c0, c1);
      if (!(r.mode == MODE_LOAD && r.endpoint_a >= MAP_DEPTH)) items_sent++;
      if (r.mode == MODE_EDGE) edges_sent++;
      if (n_typed >= 0) begin
         n = n_typed;
         c0 = t0;
         c1 = t1;
      end
      if (n > 0) pending_copies = {pending_copies, c0};
      if (n > 1) pending_copies = {pending_copies, c1};
   endtask

   // brings the block to idle: all copies in, then room for a copy-less edge
   task automatic settle();
      if (!settled) begin
         start <= 1'b0;
         while (pending_copies.size() != 0) @(posedge clock);
         repeat (SETTLE_CYCLES) @(posedge clock);
         settled = 1'b1;
      end
   endtask

   task automatic write_reg(logic [2:0] idx, logic [NODE_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      apply_csr(idx, val);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // ---------------------------------------------------------- stimulus helpers
   function automatic stim_row_type item_row(logic m, logic [EP_W-1:0] a, logic [EP_W-1:0] b,
                                             int n = -1, rsp_type e0 = '0, rsp_type e1 = '0);
      stim_row_type row;
      row.kind = ROW_ITEM;
      row.req = '{mode: m, endpoint_a: a, endpoint_b: b};
      row.csr_idx = '0;
      row.csr_val = '0;
      row.n_typed = n;
      row.exp0 = e0;
      row.exp1 = e1;
      return row;
   endfunction

   function automatic stim_row_type csr_row(logic [2:0] idx, logic [NODE_W-1:0] val);
      stim_row_type row;
      row = item_row(MODE_LOAD, '0, '0);
      row.kind = ROW_CSR;
      row.csr_idx = idx;
      row.csr_val = val;
      return row;
   endfunction

   function automatic int unsigned pick_size(int unsigned nodes);
      case ($urandom_range(7, 0))
         0:       return 0;
         1:       return 17'h1FFFF;
         2:       return MAP_DEPTH;
         default: return $urandom_range((nodes >> 2) + 1, 1);
      endcase
   endfunction

   // new node number for a load; the top four bits are never stored
   function automatic logic [EP_W-1:0] map_value(int unsigned nodes);
      int unsigned low;
      if (nodes == 0 || $urandom_range(4, 0) == 0) low = $urandom_range(16'hFFFF, 0);
      else low = $urandom_range(((nodes < MAP_DEPTH) ? nodes : MAP_DEPTH) - 1, 0);
      return EP_W'({$urandom_range(15, 0), 16'(low)});
   endfunction

   // local endpoints inside the map come only from map entries already written, so an
   // unwritten entry is never read
   function automatic logic [EP_W-1:0] pick_endpoint(int unsigned nodes);
      int unsigned sel, cand;
      sel = $urandom_range(9, 0);
      if (sel == 2 && nodes > MAP_DEPTH) return EP_W'($urandom_range(nodes - 1, MAP_DEPTH));
      if (sel >= 3 && loaded_nodes.size() > 0) begin
         for (int t = 0; t < 8; t++) begin
            cand = loaded_nodes[$urandom_range(loaded_nodes.size() - 1, 0)];
            if (cand < nodes) return EP_W'(cand);
         end
      end
      return EP_W'($urandom_range(20'hFFFFF, nodes));
   endfunction

   // one random configuration followed by map loads and a burst of edges mixed with more loads
   task automatic random_phase();
      int unsigned nodes, map_top, n_edges, sel, devs, tmp;
      int unsigned bound [3];
      req_type     r;
      settle();
      no_idle = ($urandom_range(3, 0) == 0);
      case ($urandom_range(9, 0))
         0:       nodes = 0;
         1:       nodes = MAP_DEPTH;
         2:       nodes = 17'h1FFFF;               // reaches past the map
         3, 4:    nodes = $urandom_range(MAP_DEPTH, 1);
         default: nodes = $urandom_range(64, 1);
      endcase
      devs = ($urandom_range(3, 0) == 0) ? $urandom_range(7, 0) : $urandom_range(4, 2);
      if ($urandom_range(5, 0) == 0) begin
         // unordered boundaries anywhere in the register range
         for (int i = 0; i < 3; i++) bound[i] = $urandom_range(17'h1FFFF, 0);
      end else begin
         for (int i = 0; i < 3; i++) bound[i] = $urandom_range(nodes, 0);
         if (bound[0] > bound[1]) begin tmp = bound[0]; bound[0] = bound[1]; bound[1] = tmp; end
         if (bound[1] > bound[2]) begin tmp = bound[1]; bound[1] = bound[2]; bound[2] = tmp; end
         if (bound[0] > bound[1]) begin tmp = bound[0]; bound[0] = bound[1]; bound[1] = tmp; end
      end
      write_reg(CSR_NODE_COUNT, NODE_W'(nodes));
      write_reg(CSR_DEVICE_COUNT, NODE_W'(devs));
      write_reg(CSR_CPU_PART_SIZE, NODE_W'(pick_size(nodes)));
      write_reg(CSR_GPU_PART_SIZE, NODE_W'(pick_size(nodes)));
      write_reg(CSR_START_DEV1, NODE_W'(bound[0]));
      write_reg(CSR_START_DEV2, NODE_W'(bound[1]));
      write_reg(CSR_START_DEV3, NODE_W'(bound[2]));
      phases++;

      // fill the low end of the map so edges have local nodes to hit
      map_top = (nodes < MAP_DEPTH) ? nodes : MAP_DEPTH;
      for (int unsigned i = 0; i < 48 && i < map_top; i++) begin
         r = '{mode: MODE_LOAD, endpoint_a: EP_W'(i), endpoint_b: map_value(nodes)};
         send_item(r);
      end
      if (map_top > 0) begin
         repeat (12) begin
            r = '{mode: MODE_LOAD, endpoint_a: EP_W'($urandom_range(map_top - 1, 0)),
                  endpoint_b: map_value(nodes)};
            send_item(r);
         end
      end

      n_edges = $urandom_range(160, 60);
      repeat (n_edges) begin
         sel = $urandom_range(99, 0);
         if (sel < 3) begin
            // load index past the map, dropped by the block
            r = '{mode: MODE_LOAD, endpoint_a: EP_W'($urandom_range(20'hFFFFF, MAP_DEPTH)),
                  endpoint_b: EP_W'($urandom())};
         end else if (sel < 10 && map_top > 0) begin
            r = '{mode: MODE_LOAD, endpoint_a: EP_W'($urandom_range(map_top - 1, 0)),
                  endpoint_b: map_value(nodes)};
         end else begin
            r = '{mode: MODE_EDGE, endpoint_a: pick_endpoint(nodes),
                  endpoint_b: pick_endpoint(nodes)};
         end
         send_item(r);
      end
   endtask

   // ------------------------------------------------------------ main sequence
   initial begin : stimulus
      stim_row_type stim_table [$];
      int unsigned  directed_items;

      // model starts from the reset values of the block
      cfg_nodes    = '0;
      cfg_devices  = 3'd2;
      cfg_cpu_size = NODE_W'(1);
      cfg_gpu_size = NODE_W'(1);
      foreach (cfg_start[i]) cfg_start[i] = '0;
      foreach (edge_count[i]) edge_count[i] = '0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // after reset there are no local nodes, so nothing is routed
      stim_table = {stim_table, item_row(MODE_EDGE, 20'd5, 20'd7, 0)};
      // two devices, cpu partitions of 4 nodes, gpu partitions of 2 from node 8
      stim_table = {stim_table, csr_row(CSR_NODE_COUNT, 17'd16)};
      stim_table = {stim_table, csr_row(CSR_DEVICE_COUNT, 17'd2)};
      stim_table = {stim_table, csr_row(CSR_CPU_PART_SIZE, 17'd4)};
      stim_table = {stim_table, csr_row(CSR_GPU_PART_SIZE, 17'd2)};
      stim_table = {stim_table, csr_row(CSR_START_DEV1, 17'd8)};
      stim_table = {stim_table, csr_row(CSR_START_DEV2, 17'd0)};
      stim_table = {stim_table, csr_row(CSR_START_DEV3, 17'd0)};
      // only the low 16 bits of the new number are kept, so node 0 becomes 5
      stim_table = {stim_table, item_row(MODE_LOAD, 20'd0, 20'hF0005, 0)};
      stim_table = {stim_table, item_row(MODE_LOAD, 20'd1, 20'd12, 0)};
      stim_table = {stim_table, item_row(MODE_LOAD, 20'hFFFFF, 20'd3, 0)};   // past the map
      stim_table = {stim_table, item_row(MODE_LOAD, 20'd2, 20'd15, 0)};
      // cpu partition 1 and gpu partition 2: one copy to each
      stim_table = {stim_table, item_row(MODE_EDGE, 20'd0, 20'd1, 2,
         '{2'd0, 16'd1, 20'd5, 20'd12, 24'd1, 1'b0},
         '{2'd1, 16'd2, 20'd5, 20'd12, 24'd1, 1'b1})};
      // remote second endpoint keeps its value and gets no copy
      stim_table = {stim_table, item_row(MODE_EDGE, 20'd0, 20'hFFFFF, 1,
         '{2'd0, 16'd1, 20'd5, 20'hFFFFF, 24'd2, 1'b1})};
      stim_table = {stim_table, item_row(MODE_EDGE, 20'hFFFFF, 20'hFFFFF, 0)};
      stim_table = {stim_table, item_row(MODE_EDGE, 20'd1, 20'd2)};   // same gpu, two partitions
      stim_table = {stim_table, item_row(MODE_EDGE, 20'd1, 20'd1)};   // same partition, one copy
      stim_table = {stim_table, item_row(MODE_EDGE, 20'd0, 20'd0)};   // both on the cpu
      stim_table = {stim_table, item_row(MODE_EDGE, 20'd16, 20'd0)};  // remote first endpoint
      // device count above the limit, zero cpu size, widest gpu size, boundaries out
      // of order, and node count past the map
      stim_table = {stim_table, csr_row(CSR_DEVICE_COUNT, 17'd7)};
      stim_table = {stim_table, csr_row(CSR_NODE_COUNT, 17'h1FFFF)};
      stim_table = {stim_table, csr_row(CSR_CPU_PART_SIZE, 17'd0)};
      stim_table = {stim_table, csr_row(CSR_GPU_PART_SIZE, 17'h1FFFF)};
      stim_table = {stim_table, csr_row(CSR_START_DEV1, 17'd1000)};
      stim_table = {stim_table, csr_row(CSR_START_DEV2, 17'd100)};
      stim_table = {stim_table, csr_row(CSR_START_DEV3, 17'h10000)};
      // local but past the map
      stim_table = {stim_table, item_row(MODE_EDGE, 20'h1FFFE, 20'h10000)};
      // first just out of range
      stim_table = {stim_table, item_row(MODE_EDGE, 20'h1FFFF, 20'd2)};
      stim_table = {stim_table, item_row(MODE_EDGE, 20'd1, 20'd0)};
      // device count below two, whole range on the cpu: quotient wider than 16 bits
      stim_table = {stim_table, csr_row(CSR_DEVICE_COUNT, 17'd0)};
      stim_table = {stim_table, csr_row(CSR_START_DEV1, 17'h1FFFF)};
      stim_table = {stim_table, item_row(MODE_EDGE, 20'h1FFFE, 20'h10005)};
      stim_table = {stim_table, item_row(MODE_EDGE, 20'h1FFFE, 20'd1)};

      no_idle = 1'b0;
      foreach (stim_table[i]) begin
         if (stim_table[i].kind == ROW_CSR) begin
            settle();
            write_reg(stim_table[i].csr_idx, stim_table[i].csr_val);
         end else begin
            send_item(stim_table[i].req, stim_table[i].n_typed,
                      stim_table[i].exp0, stim_table[i].exp1);
         end
      end
      directed_items = items_sent;

      // random part: a fresh configuration per phase until enough requests are in
      while (items_sent - directed_items < RANDOM_ITEMS) random_phase();

      settle();
      $display("%0d requests (%0d edges) over %0d random configurations plus the directed table,",
               items_sent, edges_sent, phases);
      $display("%0d edge copies checked, %0d mismatches", copies_seen, mismatches);
      if (mismatches == 0) $display("tb_graph_edge_partition_router passed");
      else                 $display("tb_graph_edge_partition_router failed");
      $finish;
   end

endmodule
